// ===== rtl/core/pressure_temp_compensation_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pressure/temperature compensation block
// Shared property forms: same-cycle and next-cycle implication, both
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// ante holds at an edge -> cons holds at the same edge
`define PTC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ptc: same-cycle check failed");

// ante holds at an edge -> cons holds at the next edge
`define PTC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ptc: next-cycle check failed");

`endif

// ===== rtl/core/ptc_pkg.sv =====
// ---------------------------------------------------------------------------
// ptc_pkg
// Types, widths and constants of the pressure/temperature compensation
// datapath.
// ---------------------------------------------------------------------------
package ptc_pkg;

	// Port field widths
	localparam int RAW_W      = 24;
	localparam int CAL_W      = 16;
	localparam int POFS_W     = 18;
	localparam int TEMP_W     = 20;
	localparam int PRESS_W    = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 18;

	// Internal widths, sized from the value ranges of each term
	localparam int DT_W       = 26;
	localparam int CPROD_W    = CAL_W + 1 + DT_W;
	localparam int DSQ_W      = 49;
	localparam int SENS_W     = 40;
	localparam int OFF_W      = 44;
	localparam int TQ_W       = 20;
	localparam int TI_W       = 18;
	localparam int SQ_W       = 38;
	localparam int CORR_W     = 42;
	localparam int PROD_SPLIT = 20;
	localparam int PLO_W      = RAW_W + PROD_SPLIT;
	localparam int PHI_W      = RAW_W + 1 + SENS_W - PROD_SPLIT;
	localparam int PROD_W     = 64;
	localparam int A_W        = 44;
	localparam int B_W        = 46;
	localparam int MAG_W      = 30;
	localparam int RECIP_W    = 31;

	// Scaling shifts
	localparam int SENS_SH_2B   = 7;
	localparam int SENS_SH_30B  = 8;
	localparam int OFF_SH_2B    = 6;
	localparam int OFF_SH_30B   = 7;
	localparam int TEMP_SH      = 23;
	localparam int TI_SH_2B     = 35;
	localparam int TI_SH_LO     = 33;
	localparam int TI_SH_HI     = 36;
	localparam int PROD_SH      = 21;
	localparam int OUT_SH_2B    = 15;
	localparam int OUT_SH_30B   = 13;

	// Final decimal divide: reciprocal, its shift and the divisor
	localparam logic [RECIP_W-1:0] RECIP_2B  = 31'd1374389534;
	localparam logic [RECIP_W-1:0] RECIP_30B = 31'd1717986918;
	localparam int RECIP_SH_2B  = 37;
	localparam int RECIP_SH_30B = 34;
	localparam int DIV_2B       = 100;
	localparam int DIV_30B      = 10;

	// Temperature bands
	localparam logic signed [TEMP_W-1:0] TEMP_REF    = TEMP_W'(2000);
	localparam logic signed [TQ_W-1:0]   TQ_VLOW     = TQ_W'(-3500);
	localparam logic signed [TQ_W-1:0]   TQ_VLOW_OFS = TQ_W'(3500);

	localparam logic MODEL_2BAR = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODEL_SELECT    = 4'd0,
		REG_SENS_BASE       = 4'd1,
		REG_OFF_BASE        = 4'd2,
		REG_SENS_TEMP_COEF  = 4'd3,
		REG_OFF_TEMP_COEF   = 4'd4,
		REG_REF_TEMP        = 4'd5,
		REG_TEMP_COEF       = 4'd6,
		REG_PRESSURE_OFFSET = 4'd7
	} ptc_reg_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} ptc_in_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0]  temperature;
		logic signed [PRESS_W-1:0] pressure;
	} ptc_out_t;

	typedef struct packed {
		logic                      model_select;
		logic [CAL_W-1:0]          sens_base;
		logic [CAL_W-1:0]          off_base;
		logic [CAL_W-1:0]          sens_temp_coef;
		logic [CAL_W-1:0]          off_temp_coef;
		logic [CAL_W-1:0]          ref_temp;
		logic [CAL_W-1:0]          temp_coef;
		logic signed [POFS_W-1:0]  pressure_offset;
	} ptc_cfg_t;

	// Beat handed from the compensation stages to the pressure stages
	typedef struct packed {
		logic                      valid;
		logic [RAW_W-1:0]          raw_pressure;
		logic signed [SENS_W-1:0]  sens;
		logic signed [OFF_W-1:0]   off;
		logic signed [TEMP_W-1:0]  temperature;
	} ptc_comp_t;

endpackage

// ===== rtl/core/ptc_comp_stage.sv =====
// ---------------------------------------------------------------------------
// ptc_comp_stage
// Six-stage front end: temperature delta, coefficient products, first-order
// sensitivity/offset/temperature, squared terms, band corrections.
// ---------------------------------------------------------------------------
`include "pressure_temp_compensation_assert.svh"

module ptc_comp_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  ptc_pkg::ptc_in_t    sample,
	input  ptc_pkg::ptc_cfg_t   cfg,
	output ptc_pkg::ptc_comp_t  comp
);
	import ptc_pkg::*;

	logic two_bar;
	assign two_bar = (cfg.model_select == MODEL_2BAR);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [RAW_W-1:0] d1_s1, d1_s2, d1_s3, d1_s4, d1_s5;

	// Stage 1
	logic signed [DT_W-1:0] dt_s1;

	// Stage 2
	logic signed [CAL_W:0]      c3, c4, c6;
	logic signed [2*DT_W-1:0]   dsq_full;
	logic signed [CPROD_W-1:0]  pc3_s2, pc4_s2, pc6_s2;
	logic [DSQ_W-1:0]           dsq_s2;

	// Stage 3
	logic signed [CPROD_W-1:0]  pc3_b7, pc3_b8, pc4_b6, pc4_b7, pc6_b23;
	logic signed [SENS_W-1:0]   sens_a, sens_b, sens1_s3;
	logic signed [OFF_W-1:0]    off_a, off_b, off1_s3;
	logic [DSQ_W+3:0]           dsq11;
	logic [DSQ_W+1:0]           dsq3;
	logic signed [TQ_W-1:0]     q6_s3;
	logic [TI_W-1:0]            ti11_s3, ti3_s3, ti2_s3;

	// Stage 4
	logic signed [TQ_W-1:0]     q6p;
	logic signed [2*TQ_W-1:0]   t2_full, t3_full;
	logic [SQ_W-1:0]            t2_s4, t3_s4;
	logic                       low_s4, vlow_s4;
	logic signed [TEMP_W-1:0]   temp1_s4;
	logic [TI_W-1:0]            ti_s4;
	logic signed [SENS_W-1:0]   sens1_s4;
	logic signed [OFF_W-1:0]    off1_s4;

	// Stage 5
	logic [CORR_W-1:0]          t2e, t3e, offi, sensi, offi_s5, sensi_s5;
	logic signed [TEMP_W-1:0]   temp_s5;
	logic signed [SENS_W-1:0]   sens1_s5;
	logic signed [OFF_W-1:0]    off1_s5;

	// Stage 6
	logic                       v_s6;
	logic [RAW_W-1:0]           d1_s6;
	logic signed [SENS_W-1:0]   sens_s6;
	logic signed [OFF_W-1:0]    off_s6;
	logic signed [TEMP_W-1:0]   temp_s6;

	assign c3 = $signed({1'b0, cfg.sens_temp_coef});
	assign c4 = $signed({1'b0, cfg.off_temp_coef});
	assign c6 = $signed({1'b0, cfg.temp_coef});
	assign dsq_full = dt_s1 * dt_s1;

	// Truncate toward zero: bias negative values before the arithmetic shift
	assign pc3_b7  = pc3_s2 + (pc3_s2[CPROD_W-1] ? CPROD_W'((1 << SENS_SH_2B) - 1)  : CPROD_W'(0));
	assign pc3_b8  = pc3_s2 + (pc3_s2[CPROD_W-1] ? CPROD_W'((1 << SENS_SH_30B) - 1) : CPROD_W'(0));
	assign pc4_b6  = pc4_s2 + (pc4_s2[CPROD_W-1] ? CPROD_W'((1 << OFF_SH_2B) - 1)   : CPROD_W'(0));
	assign pc4_b7  = pc4_s2 + (pc4_s2[CPROD_W-1] ? CPROD_W'((1 << OFF_SH_30B) - 1)  : CPROD_W'(0));
	assign pc6_b23 = pc6_s2 + (pc6_s2[CPROD_W-1] ? CPROD_W'((1 << TEMP_SH) - 1)     : CPROD_W'(0));

	assign sens_a = SENS_W'({1'b0, cfg.sens_base, 16'h0000}) + SENS_W'(pc3_b7 >>> SENS_SH_2B);
	assign sens_b = SENS_W'({1'b0, cfg.sens_base, 15'h0000}) + SENS_W'(pc3_b8 >>> SENS_SH_30B);
	assign off_a  = OFF_W'({1'b0, cfg.off_base, 17'h00000}) + OFF_W'(pc4_b6 >>> OFF_SH_2B);
	assign off_b  = OFF_W'({1'b0, cfg.off_base, 16'h0000}) + OFF_W'(pc4_b7 >>> OFF_SH_30B);

	// dt squared is never negative, so the low-band shifts are floors
	assign dsq11 = {1'b0, dsq_s2, 3'b000} + {3'b000, dsq_s2, 1'b0} + {4'b0000, dsq_s2};
	assign dsq3  = {1'b0, dsq_s2, 1'b0} + {2'b00, dsq_s2};

	assign q6p     = q6_s3 + TQ_VLOW_OFS;
	assign t2_full = q6_s3 * q6_s3;
	assign t3_full = q6p * q6p;

	assign t2e = CORR_W'(t2_s4);
	assign t3e = CORR_W'(t3_s4);

	always_comb begin
		if (two_bar) begin
			if (low_s4) begin
				offi  = ((t2e << 5) - t2e) >> 3;
				sensi = ((t2e << 6) - t2e) >> 5;
			end else begin
				offi  = '0;
				sensi = '0;
			end
		end else if (low_s4) begin
			offi  = (((t2e << 1) + t2e) >> 1) + (vlow_s4 ? ((t3e << 3) - t3e) : '0);
			sensi = (((t2e << 2) + t2e) >> 3) + (vlow_s4 ? (t3e << 2) : '0);
		end else begin
			offi  = t2e >> 4;
			sensi = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		d1_s1 <= sample.raw_pressure;
		dt_s1 <= $signed({2'b00, sample.raw_temperature}) - $signed({2'b00, cfg.ref_temp, 8'h00});

		d1_s2  <= d1_s1;
		pc3_s2 <= c3 * dt_s1;
		pc4_s2 <= c4 * dt_s1;
		pc6_s2 <= c6 * dt_s1;
		dsq_s2 <= dsq_full[DSQ_W-1:0];

		d1_s3    <= d1_s2;
		sens1_s3 <= two_bar ? sens_a : sens_b;
		off1_s3  <= two_bar ? off_a : off_b;
		q6_s3    <= TQ_W'(pc6_b23 >>> TEMP_SH);
		ti11_s3  <= TI_W'(dsq11 >> TI_SH_2B);
		ti3_s3   <= TI_W'(dsq3 >> TI_SH_LO);
		ti2_s3   <= TI_W'(dsq_s2 >> TI_SH_HI);

		d1_s4    <= d1_s3;
		sens1_s4 <= sens1_s3;
		off1_s4  <= off1_s3;
		t2_s4    <= t2_full[SQ_W-1:0];
		t3_s4    <= t3_full[SQ_W-1:0];
		low_s4   <= q6_s3[TQ_W-1];
		vlow_s4  <= (q6_s3 < TQ_VLOW);
		temp1_s4 <= TEMP_W'(q6_s3) + TEMP_REF;
		if (two_bar)
			ti_s4 <= q6_s3[TQ_W-1] ? ti11_s3 : '0;
		else
			ti_s4 <= q6_s3[TQ_W-1] ? ti3_s3 : ti2_s3;

		d1_s5    <= d1_s4;
		sens1_s5 <= sens1_s4;
		off1_s5  <= off1_s4;
		offi_s5  <= offi;
		sensi_s5 <= sensi;
		temp_s5  <= temp1_s4 - $signed({2'b00, ti_s4});

		d1_s6   <= d1_s5;
		sens_s6 <= sens1_s5 - SENS_W'(sensi_s5);
		off_s6  <= off1_s5 - OFF_W'(offi_s5);
		temp_s6 <= temp_s5;
	end

	assign comp = '{valid: v_s6, raw_pressure: d1_s6, sens: sens_s6, off: off_s6,
		temperature: temp_s6};

	`PTC_ASSERT_IMPLY(a_comp_latency, clk, arst_n, v_s6, $past(v_s1, 5))
	`PTC_ASSERT_IMPLY(a_band_nesting, clk, arst_n, v_s4 && vlow_s4, low_s4)

endmodule

// ===== rtl/core/ptc_press_stage.sv =====
// ---------------------------------------------------------------------------
// ptc_press_stage
// Eight-stage back end: split pressure product, scale, subtract offset,
// decimal divide by reciprocal with one correction step, final offset (30 bar model only).
// ---------------------------------------------------------------------------
`include "pressure_temp_compensation_assert.svh"

module ptc_press_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  ptc_pkg::ptc_comp_t  comp,
	input  ptc_pkg::ptc_cfg_t   cfg,
	output logic                done,
	output ptc_pkg::ptc_out_t   result
);
	import ptc_pkg::*;

	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, done_s14;
	logic m_s7, m_s8, m_s9, m_s10, m_s11, m_s12, m_s13;
	logic signed [TEMP_W-1:0] temp_s7, temp_s8, temp_s9, temp_s10, temp_s11, temp_s12, temp_s13;
	logic signed [OFF_W-1:0]  off_s7, off_s8, off_s9;

	// Stage 7
	logic [PROD_SPLIT-1:0]               sens_lo;
	logic signed [SENS_W-PROD_SPLIT-1:0] sens_hi;
	logic [PLO_W-1:0]                    plo_s7;
	logic signed [PHI_W-1:0]             phi_s7;

	// Stages 8 to 10
	logic signed [PROD_W-1:0] prod_s8;
	logic signed [A_W-1:0]    a_s9;
	logic signed [B_W-1:0]    b_s10;

	// Stages 11 to 14
	logic [B_W-1:0]             absb;
	logic [MAG_W-1:0]           mag_s11, mag_s12;
	logic                       neg_s11, neg_s12, neg_s13;
	logic [RECIP_W-1:0]         recip;
	logic [MAG_W+RECIP_W-1:0]   rmul;
	logic [MAG_W-1:0]           q_est_s12, qd, rem, divisor, q_s13;
	logic [PRESS_W-1:0]         pval;
	ptc_out_t                   result_s14;

	assign sens_lo = comp.sens[PROD_SPLIT-1:0];
	assign sens_hi = $signed(comp.sens[SENS_W-1:PROD_SPLIT]);

	assign absb  = b_s10[B_W-1] ? -b_s10 : b_s10;
	assign recip = m_s11 ? RECIP_2B : RECIP_30B;
	assign rmul  = mag_s11 * recip;

	assign divisor = m_s12 ? MAG_W'(DIV_2B) : MAG_W'(DIV_30B);
	assign qd      = m_s12 ? q_est_s12 * MAG_W'(DIV_2B) : q_est_s12 * MAG_W'(DIV_30B);
	assign rem     = mag_s12 - qd;

	always_comb begin
		pval = neg_s13 ? -PRESS_W'(q_s13) : PRESS_W'(q_s13);
		if (!m_s13)
			pval = pval + PRESS_W'(cfg.pressure_offset);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			v_s10    <= 1'b0;
			v_s11    <= 1'b0;
			v_s12    <= 1'b0;
			v_s13    <= 1'b0;
			done_s14 <= 1'b0;
		end else begin
			v_s7     <= comp.valid;
			v_s8     <= v_s7;
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			v_s11    <= v_s10;
			v_s12    <= v_s11;
			v_s13    <= v_s12;
			done_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		m_s7    <= (cfg.model_select == MODEL_2BAR);
		temp_s7 <= comp.temperature;
		off_s7  <= comp.off;
		plo_s7  <= comp.raw_pressure * sens_lo;
		phi_s7  <= $signed({1'b0, comp.raw_pressure}) * sens_hi;

		m_s8    <= m_s7;
		temp_s8 <= temp_s7;
		off_s8  <= off_s7;
		prod_s8 <= (PROD_W'(phi_s7) <<< PROD_SPLIT) + PROD_W'(plo_s7);

		m_s9    <= m_s8;
		temp_s9 <= temp_s8;
		off_s9  <= off_s8;
		a_s9    <= A_W'((prod_s8 + (prod_s8[PROD_W-1] ? PROD_W'((1 << PROD_SH) - 1)
			: PROD_W'(0))) >>> PROD_SH);

		m_s10    <= m_s9;
		temp_s10 <= temp_s9;
		b_s10    <= B_W'(a_s9) - B_W'(off_s9);

		// Work on the magnitude: a floor of |b| is a truncation of b
		m_s11    <= m_s10;
		temp_s11 <= temp_s10;
		neg_s11  <= b_s10[B_W-1];
		mag_s11  <= m_s10 ? MAG_W'(absb >> OUT_SH_2B) : MAG_W'(absb >> OUT_SH_30B);

		m_s12     <= m_s11;
		temp_s12  <= temp_s11;
		neg_s12   <= neg_s11;
		mag_s12   <= mag_s11;
		q_est_s12 <= m_s11 ? MAG_W'(rmul >> RECIP_SH_2B) : MAG_W'(rmul >> RECIP_SH_30B);

		// The estimate is low by at most one
		m_s13    <= m_s12;
		temp_s13 <= temp_s12;
		neg_s13  <= neg_s12;
		q_s13    <= (rem >= divisor) ? q_est_s12 + 1'b1 : q_est_s12;

		result_s14.temperature <= temp_s13;
		result_s14.pressure    <= pval;
	end

	assign done   = done_s14;
	assign result = result_s14;

	`PTC_ASSERT_IMPLY(a_press_latency, clk, arst_n, done_s14, $past(v_s7, 7))
	`PTC_ASSERT_IMPLY(a_recip_bound, clk, arst_n, v_s12,
		(qd <= mag_s12) && ((mag_s12 - qd) < (divisor << 1)))
	`PTC_ASSERT_NEXT(a_recip_fix, clk, arst_n, v_s12,
		(q_s13 == $past(q_est_s12)) || (q_s13 == $past(q_est_s12) + 1'b1))

endmodule

// ===== rtl/core/pressure_temp_compensation.sv =====
// ---------------------------------------------------------------------------
// pressure_temp_compensation
// Converts a raw 24-bit pressure and temperature pair into temperature in
// hundredths of a degree C and second-order compensated pressure. A pair is
// taken on every clock where start is high; busy is always low, so a new
// pair may follow in the very next cycle. Each result passes through the
// fourteen registers of the datapath, from stage 1 to the done register, and
// then sits on result, with done high, for a single cycle; results leave in
// the order the pairs came in. The receiver cannot stall: a result not taken
// in its done cycle is gone. Calibration and model
// registers are written through cfg_we/cfg_index/cfg_wdata, take effect at
// once, and must be written only while no pair is in flight; indexes above
// the pressure offset register are ignored.
// ---------------------------------------------------------------------------
module pressure_temp_compensation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  ptc_pkg::ptc_in_t                      sample,
	output logic                                  done,
	output ptc_pkg::ptc_out_t                     result,
	input  logic                                  cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ptc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import ptc_pkg::*;

	ptc_cfg_t  cfg_q;
	ptc_comp_t comp;
	logic      accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODEL_SELECT:    cfg_q.model_select    <= cfg_wdata[0];
				REG_SENS_BASE:       cfg_q.sens_base       <= cfg_wdata[CAL_W-1:0];
				REG_OFF_BASE:        cfg_q.off_base        <= cfg_wdata[CAL_W-1:0];
				REG_SENS_TEMP_COEF:  cfg_q.sens_temp_coef  <= cfg_wdata[CAL_W-1:0];
				REG_OFF_TEMP_COEF:   cfg_q.off_temp_coef   <= cfg_wdata[CAL_W-1:0];
				REG_REF_TEMP:        cfg_q.ref_temp        <= cfg_wdata[CAL_W-1:0];
				REG_TEMP_COEF:       cfg_q.temp_coef       <= cfg_wdata[CAL_W-1:0];
				REG_PRESSURE_OFFSET: cfg_q.pressure_offset <= $signed(cfg_wdata[POFS_W-1:0]);
				default: ;
			endcase
		end
	end

	ptc_comp_stage u_comp (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.cfg    (cfg_q),
		.comp   (comp)
	);

	ptc_press_stage u_press (
		.clk    (clk),
		.arst_n (arst_n),
		.comp   (comp),
		.cfg    (cfg_q),
		.done   (done),
		.result (result)
	);

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Pressure/temperature compensation testbench
// Drives raw pressure and temperature pairs into the block and checks every
// result beat, against table values or a predictor of the first-order and
// second-order compensation, over both models and several calibration sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import ptc_pkg::*;

	localparam int RESET_CYCLES  = 6;
	localparam int SETS_PER_MODE = 5;
	localparam int ITEMS_PER_SET = 84;
	localparam int SETTLE_CYCLES = 2;
	localparam int DRAIN_CYCLES  = 24;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int MAX_REPORTS   = 40;
	localparam int DIR_ROWS      = 43;

	// Register indexes past the last register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

	// Typical calibration words of a 30 bar part
	localparam logic [CFG_DATA_W-1:0] CAL_SENS  = 18'd34982;
	localparam logic [CFG_DATA_W-1:0] CAL_OFF   = 18'd36352;
	localparam logic [CFG_DATA_W-1:0] CAL_TCS   = 18'd20328;
	localparam logic [CFG_DATA_W-1:0] CAL_TCO   = 18'd22354;
	localparam logic [CFG_DATA_W-1:0] CAL_TREF  = 18'd26646;
	localparam logic [CFG_DATA_W-1:0] CAL_TSENS = 18'd26146;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_IDX_W-1:0]      index;
		logic [CFG_DATA_W-1:0]     wdata;
		logic [RAW_W-1:0]          raw_p;
		logic [RAW_W-1:0]          raw_t;
		logic                      typed;
		logic signed [TEMP_W-1:0]  exp_t;
		logic signed [PRESS_W-1:0] exp_p;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	ptc_in_t               sample = '0;
	logic                  done;
	ptc_out_t              result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	ptc_cfg_t cal = '0;
	ptc_out_t pending [$];
	ptc_out_t oldest;
	int       errors = 0;
	int       gap_pct = 0;
	int       cycle_count = 0;

	// Samples that follow reset with raw temperature zero give 20.00 C and zero pressure
	stim_row_t dir_table [DIR_ROWS] = '{
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'h000000, 24'h000000, 1'b1, 20'sd2000, 32'sd0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'hFFFFFF, 24'h000000, 1'b1, 20'sd2000, 32'sd0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'h000000, 24'hFFFFFF, 1'b0, '0, '0},
		'{ROW_WRITE, REG_MODEL_SELECT, 18'd0, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_SENS_BASE, CAL_SENS, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_OFF_BASE, CAL_OFF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_SENS_TEMP_COEF, CAL_TCS, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_OFF_TEMP_COEF, CAL_TCO, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_REF_TEMP, CAL_TREF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_TEMP_COEF, CAL_TSENS, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_PRESSURE_OFFSET, 18'd0, '0, '0, 1'b0, '0, '0},
		// exactly 20 C, just below it, room temperature, near -15 C, very cold, hot
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd6821376, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd6821055, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd6815414, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd5698446, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd4821376, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd9000000, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'hFFFFFF, 24'h000000, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'h000000, 24'hFFFFFF, 1'b0, '0, '0},
		'{ROW_WRITE, REG_PRESSURE_OFFSET, 18'h1FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd5000000, 24'd7000000, 1'b0, '0, '0},
		'{ROW_WRITE, REG_PRESSURE_OFFSET, 18'h20000, '0, '0, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd5000000, 24'd7000000, 1'b0, '0, '0},
		'{ROW_WRITE, REG_MODEL_SELECT, 18'd1, '0, '0, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd6821376, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd6821055, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd3000000, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd4958179, 24'd9000000, 1'b0, '0, '0},
		// all-ones data; the upper bits must be dropped by the 16-bit words
		'{ROW_WRITE, REG_SENS_BASE, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_OFF_BASE, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_SENS_TEMP_COEF, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_OFF_TEMP_COEF, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_REF_TEMP, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_TEMP_COEF, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'hFFFFFF, 24'h000000, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0},
		'{ROW_WRITE, REG_MODEL_SELECT, 18'h3FFFE, '0, '0, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'hFFFFFF, 24'h000000, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, '0},
		'{ROW_WRITE, REG_UNUSED_LO, 18'h3FFFF, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_UNUSED_HI, 18'h00000, '0, '0, 1'b0, '0, '0},
		'{ROW_SAMPLE, REG_MODEL_SELECT, '0, 24'd123456, 24'd654321, 1'b0, '0, '0}
	};

	pressure_temp_compensation DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Temperature and second-order compensated pressure of one pair
	function automatic ptc_out_t compensate(input ptc_cfg_t c, input ptc_in_t s);
		longint   d1, d2, dt, tq, first, dev2, cold, gain, base;
		longint   t_corr, off_corr, sens_corr, p, t_final;
		logic     two_bar;
		ptc_out_t res;
		d1 = longint'(s.raw_pressure);
		d2 = longint'(s.raw_temperature);
		two_bar = (c.model_select == MODEL_2BAR);
		dt = d2 - longint'(c.ref_temp) * 256;
		if (two_bar) begin
			gain = longint'(c.sens_base) * 65536 + (longint'(c.sens_temp_coef) * dt) / 128;
			base = longint'(c.off_base) * 131072 + (longint'(c.off_temp_coef) * dt) / 64;
		end else begin
			gain = longint'(c.sens_base) * 32768 + (longint'(c.sens_temp_coef) * dt) / 256;
			base = longint'(c.off_base) * 65536 + (longint'(c.off_temp_coef) * dt) / 128;
		end
		tq = (dt * longint'(c.temp_coef)) / 8388608;
		first = 2000 + tq;
		dev2 = tq * tq;
		t_corr = 0;
		off_corr = 0;
		sens_corr = 0;
		if (two_bar) begin
			if (first < 2000) begin
				t_corr = (11 * dt * dt) / 64'sd34359738368;
				off_corr = (31 * dev2) / 8;
				sens_corr = (63 * dev2) / 32;
			end
		end else if (first < 2000) begin
			t_corr = (3 * dt * dt) / 64'sd8589934592;
			off_corr = (3 * dev2) / 2;
			sens_corr = (5 * dev2) / 8;
			if (first < -1500) begin
				cold = (first + 1500) * (first + 1500);
				off_corr += 7 * cold;
				sens_corr += 4 * cold;
			end
		end else begin
			t_corr = (2 * dt * dt) / 64'sd137438953472;
			off_corr = dev2 / 16;
		end
		base -= off_corr;
		gain -= sens_corr;
		t_final = first - t_corr;
		if (two_bar)
			p = (((d1 * gain) / 2097152 - base) / 32768) / 100;
		else
			p = (((d1 * gain) / 2097152 - base) / 8192) / 10
				+ longint'($signed(c.pressure_offset));
		res.temperature = t_final[TEMP_W-1:0];
		res.pressure = p[PRESS_W-1:0];
		return res;
	endfunction

	// Random pair; most raw temperatures land near the reference so every band is hit
	function automatic ptc_in_t random_pair();
		ptc_in_t p;
		longint  t;
		int      span;
		p.raw_pressure = RAW_W'($urandom);
		if ($urandom_range(15) == 0)
			p.raw_pressure = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(3) == 0) begin
			p.raw_temperature = RAW_W'($urandom);
		end else begin
			span = 1 << $urandom_range(21, 6);
			t = longint'(cal.ref_temp) * 256 + longint'($urandom_range(2 * span)) - span;
			if (t < 0)
				t = 0;
			if (t > 64'sd16777215)
				t = 64'sd16777215;
			p.raw_temperature = t[RAW_W-1:0];
		end
		return p;
	endfunction

	// Drop start and wait until every result in flight has come out
	task automatic settle();
		start <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] wdata);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= wdata;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_MODEL_SELECT:    cal.model_select = wdata[0];
			REG_SENS_BASE:       cal.sens_base = wdata[CAL_W-1:0];
			REG_OFF_BASE:        cal.off_base = wdata[CAL_W-1:0];
			REG_SENS_TEMP_COEF:  cal.sens_temp_coef = wdata[CAL_W-1:0];
			REG_OFF_TEMP_COEF:   cal.off_temp_coef = wdata[CAL_W-1:0];
			REG_REF_TEMP:        cal.ref_temp = wdata[CAL_W-1:0];
			REG_TEMP_COEF:       cal.temp_coef = wdata[CAL_W-1:0];
			REG_PRESSURE_OFFSET: cal.pressure_offset = wdata[POFS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_pair(input ptc_in_t pair, input logic typed, input ptc_out_t known);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= pair;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending.push_back(typed ? known : compensate(cal, pair));
	endtask

	// Extremes on the first two sets of each idling mode, random words after
	task automatic load_calibration(input int cfg_set, input int mode);
		logic [CFG_DATA_W-1:0] words [8];
		settle();
		for (int r = REG_MODEL_SELECT; r <= REG_PRESSURE_OFFSET; r++) begin
			case (cfg_set)
				0: words[r] = {2'($urandom), 16'hFFFF};
				1: words[r] = '0;
				default: words[r] = CFG_DATA_W'($urandom);
			endcase
		end
		if (cfg_set == 0) begin
			words[REG_MODEL_SELECT] = CFG_DATA_W'(mode % 2);
			words[REG_PRESSURE_OFFSET] = 18'h1FFFF;
		end else if (cfg_set == 1) begin
			words[REG_MODEL_SELECT] = CFG_DATA_W'(1 - mode % 2);
			words[REG_PRESSURE_OFFSET] = 18'h20000;
		end
		for (int r = REG_MODEL_SELECT; r <= REG_PRESSURE_OFFSET; r++)
			write_reg(CFG_IDX_W'(r), words[r]);
		if (cfg_set > 1)
			write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
				CFG_DATA_W'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected beat, expected none, got temperature %0d pressure %0d",
						$time, result.temperature, result.pressure);
			end else begin
				oldest = pending.pop_front();
				if (result.temperature !== oldest.temperature) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: temperature expected %0d, got %0d",
							$time, oldest.temperature, result.temperature);
				end
				if (result.pressure !== oldest.pressure) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: pressure expected %0d, got %0d",
							$time, oldest.pressure, result.pressure);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		ptc_in_t pair;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 7;
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_WRITE) begin
				settle();
				write_reg(dir_table[i].index, dir_table[i].wdata);
			end else begin
				pair.raw_pressure = dir_table[i].raw_p;
				pair.raw_temperature = dir_table[i].raw_t;
				send_pair(pair, dir_table[i].typed,
					'{temperature: dir_table[i].exp_t, pressure: dir_table[i].exp_p});
			end
		end

		// sender idles 7 in 100, then 45 in 100, then never
		for (int mode = 0; mode < 3; mode++) begin
			gap_pct = (mode == 0) ? 7 : (mode == 1) ? 45 : 0;
			for (int cfg_set = 0; cfg_set < SETS_PER_MODE; cfg_set++) begin
				load_calibration(cfg_set, mode);
				for (int n = 0; n < ITEMS_PER_SET; n++)
					send_pair(random_pair(), 1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ptc_pkg.sv
rtl/core/ptc_comp_stage.sv
rtl/core/ptc_press_stage.sv
rtl/core/pressure_temp_compensation.sv
bench/testbench.sv
